// File: rtl/mfqs_pkg.sv
// Package: shared types, constants and command/status structs for the scheduler.
package mfqs_pkg;
    localparam int LEVELS = 4;
    localparam int TASKS = 16;
    localparam int QUANTUM_BITS = 8;
    localparam int LV_W = $clog2(LEVELS);
    localparam int TK_W = $clog2(TASKS);
    localparam int CNT_W = $clog2(TASKS + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int FUNC_W = 3;
    localparam int TASK_ID_W = 4;
    localparam int QMAX = (1 << QUANTUM_BITS) - 1;

    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNBLOCK = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_BLOCK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_EXIT    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_Q0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Q1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Q2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Q3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic                 start;   // latch request
        logic                 execute; // apply request, load result
    } mfqs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic busy;
    } mfqs_status_t;
endpackage

// File: rtl/mfqs_if.sv
// Interfaces: valid/ready request channels for events and results.
interface mfqs_in_if;
    logic                            valid;
    logic                            ready;
    logic [mfqs_pkg::FUNC_W-1:0]     func;
    logic [mfqs_pkg::TASK_ID_W-1:0]  task_id;
    modport source (output valid, func, task_id, input ready);
    modport sink (input valid, func, task_id, output ready);
endinterface

interface mfqs_out_if;
    logic                            valid;
    logic                            ready;
    logic [mfqs_pkg::TASK_ID_W-1:0]  running_task;
    logic                            running_is_idle;
    logic                            event_ignored;
    modport source (output valid, running_task, running_is_idle, event_ignored, input ready);
    modport sink (input valid, running_task, running_is_idle, event_ignored, output ready);
endinterface

// File: rtl/multilevel_feedback_queue_scheduler.sv
// Top level: multilevel feedback queue scheduler.
// A request passes through the read and execute states; its result is registered valid
// on entering the output state. The queue-store read port sets the read cycle.
// The next request is taken in the same cycle the result is taken.
// Reset (rst_n, async low): queues empty, idle running, quantums 2/4/8/16, four levels.
// Queue and return-level memories need no clearing pass.
module multilevel_feedback_queue_scheduler (
    input  logic                              clk,
    input  logic                              rst_n,
    mfqs_in_if.sink                           in_ch,
    mfqs_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [mfqs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mfqs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    mfqs_pkg::mfqs_cmd_t    cmd;
    mfqs_pkg::mfqs_status_t status;

    // Controller: accept request, read, execute, hold result.
    mfqs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .status(status));

    // Datapath: queues and the running task; outputs hold until the next execute.
    mfqs_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .func(in_ch.func), .task_id(in_ch.task_id),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .running_task(out_ch.running_task),
        .running_is_idle(out_ch.running_is_idle),
        .event_ignored(out_ch.event_ignored));
endmodule

// File: rtl/mfqs_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module mfqs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/mfqs_ctrl.sv
// Controller: sequences one request through read and execute cycles.
module mfqs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mfqs_pkg::mfqs_cmd_t    cmd,
    input  mfqs_pkg::mfqs_status_t status
);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_OUT} state_t;
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Accept while idle, or while the last result is being taken.
    assign in_ready  = (state_reg == S_IDLE) || (state_reg == S_OUT && out_ready);
    assign out_valid = out_valid_reg;
    assign cmd.start   = in_valid && in_ready;
    assign cmd.execute = (state_reg == S_EXEC);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next     = S_OUT;
                out_valid_next = 1'b1;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = in_valid ? S_READ : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (status.busy && state_reg == S_IDLE && !in_valid)
        begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// File: rtl/mfqs_datapath.sv
// Datapath: level queues, return-level store, running task and quantum.
module mfqs_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mfqs_pkg::mfqs_cmd_t                 cmd,
    output mfqs_pkg::mfqs_status_t              status,
    input  logic [mfqs_pkg::FUNC_W-1:0]         func,
    input  logic [mfqs_pkg::TASK_ID_W-1:0]      task_id,
    input  logic                                cfg_we,
    input  logic [mfqs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mfqs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [mfqs_pkg::TASK_ID_W-1:0]      running_task,
    output logic                                running_is_idle,
    output logic                                event_ignored
);
    localparam int LV_W  = mfqs_pkg::LV_W;
    localparam int TK_W  = mfqs_pkg::TK_W;
    localparam int CNT_W = mfqs_pkg::CNT_W;
    localparam int QB    = mfqs_pkg::QUANTUM_BITS;
    localparam int LV    = mfqs_pkg::LEVELS;

    logic [7:0]                  quantum_reg [4];
    logic [2:0]                  levels_reg;
    logic [TK_W-1:0]             head_reg  [LV];
    logic [TK_W-1:0]             tail_reg  [LV];
    logic [CNT_W-1:0]            count_reg [LV];
    logic [TK_W-1:0]             cur_task_reg;
    logic                        cur_idle_reg;
    logic [LV_W-1:0]             cur_level_reg;
    logic [QB-1:0]               qleft_reg;
    logic [mfqs_pkg::FUNC_W-1:0] func_reg;
    logic [mfqs_pkg::TASK_ID_W-1:0] task_reg;
    logic                        ign_reg;

    // latched request
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg <= func;
            task_reg <= task_id;
        end
    end

    // active level count and last level
    logic [LV_W:0]   nact;
    logic [LV_W-1:0] last_lv;
    always_comb
    begin
        nact = (levels_reg == 3'd0) ? (LV_W+1)'(1) :
               ({1'b0, levels_reg} > 4'(LV)) ? (LV_W+1)'(LV) : (LV_W+1)'(levels_reg);
        last_lv = LV_W'(nact - 1'b1);
    end

    function automatic logic [LV_W-1:0] clampl(input logic [LV_W:0] lv, input logic [LV_W-1:0] last);
        clampl = (lv > {1'b0, last}) ? last : lv[LV_W-1:0];
    endfunction

    // return-level store, read from the latched task during the read cycle
    logic            rl_we;
    logic [LV_W-1:0] rl_wdata, rl_rdata;
    mfqs_ram #(.WIDTH(LV_W), .DEPTH(mfqs_pkg::TASKS)) u_rl (
        .clk(clk), .we(rl_we), .waddr(cur_task_reg), .wdata(rl_wdata),
        .raddr(task_reg[TK_W-1:0]), .rdata(rl_rdata));

    // queue store: flat LEVELS x TASKS; read port aimed at head of best level
    localparam int QA_W = LV_W + TK_W;
    logic            qs_we;
    logic [QA_W-1:0] qs_waddr, qs_raddr;
    logic [TK_W-1:0] qs_wdata, qs_rdata;
    mfqs_ram #(.WIDTH(TK_W), .DEPTH(LV * mfqs_pkg::TASKS)) u_qs (
        .clk(clk), .we(qs_we), .waddr(qs_waddr), .wdata(qs_wdata),
        .raddr(qs_raddr), .rdata(qs_rdata));

    // Push decision (from latched request; an unblock's level is known only in the execute cycle)
    logic            push_en;
    logic [LV_W-1:0] push_lv;
    logic [TK_W-1:0] push_task;
    logic            push_ok;
    logic            do_select;
    logic            ign_c;
    logic            tick_dec;
    always_comb
    begin
        push_en = 1'b0; push_lv = '0; push_task = task_reg[TK_W-1:0];
        do_select = 1'b0; ign_c = 1'b0; tick_dec = 1'b0;
        rl_we = 1'b0; rl_wdata = '0;
        case (func_reg)
            mfqs_pkg::FUNC_LOAD:
            begin
                push_en = 1'b1;
            end
            mfqs_pkg::FUNC_UNBLOCK:
            begin
                push_en = 1'b1;
                push_lv = clampl({1'b0, rl_rdata}, last_lv);
            end
            mfqs_pkg::FUNC_TICK:
            begin
                if (qleft_reg != '0)
                begin
                    tick_dec = 1'b1;
                end
                else
                begin
                    do_select = 1'b1;
                    if (!cur_idle_reg)
                    begin
                        push_en   = 1'b1;
                        push_task = cur_task_reg;
                        push_lv   = clampl({1'b0, cur_level_reg} + 1'b1, last_lv);
                    end
                end
            end
            mfqs_pkg::FUNC_BLOCK:
            begin
                if (cur_idle_reg) ign_c = 1'b1;
                else
                begin
                    do_select = 1'b1;
                    rl_we     = cmd.execute;
                    rl_wdata  = clampl({1'b0, (cur_level_reg != '0) ? cur_level_reg - 1'b1
                                                                   : cur_level_reg}, last_lv);
                end
            end
            mfqs_pkg::FUNC_EXIT:
            begin
                if (cur_idle_reg) ign_c = 1'b1;
                else do_select = 1'b1;
            end
            default:
            begin
                ign_c = 1'b1;
            end
        endcase
        push_ok = push_en && (count_reg[push_lv] < CNT_W'(mfqs_pkg::TASKS));
        if (push_en && !push_ok) ign_c = 1'b1;
    end

    // Selection over pre-push counts (push lands at tail, never the head of an empty
    // level except the requeued task, handled by sel_from_push).
    logic            sel_found;
    logic [LV_W-1:0] sel_lv;
    logic            sel_from_push;
    always_comb
    begin
        sel_found = 1'b0; sel_lv = '0;
        for (int i = LV - 1; i >= 0; i--)
        begin
            if (LV_W'(i) <= last_lv &&
                (count_reg[i] != '0 || (push_ok && push_lv == LV_W'(i))))
            begin
                sel_found = 1'b1;
                sel_lv    = LV_W'(i);
            end
        end
        sel_from_push = push_ok && push_lv == sel_lv && count_reg[sel_lv] == '0;
    end

    // Read the head of the selected level during the read cycle.
    assign qs_raddr = {sel_lv, head_reg[sel_lv]};
    assign qs_we    = cmd.execute && push_ok;
    assign qs_waddr = {push_lv, tail_reg[push_lv]};
    assign qs_wdata = push_task;

    logic [7:0]    qsel;
    logic [QB-1:0] qload;
    always_comb
    begin
        qsel = quantum_reg[(sel_lv > LV_W'(3)) ? 2'd3 : 2'(sel_lv)];
        if (qsel == 8'd0) qsel = 8'd1;
        if (int'(qsel) > mfqs_pkg::QMAX)
            qload = QB'(mfqs_pkg::QMAX - 1);
        else
            qload = QB'(qsel) - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg[0] <= 8'd2; quantum_reg[1] <= 8'd4;
            quantum_reg[2] <= 8'd8; quantum_reg[3] <= 8'd16;
            levels_reg    <= 3'd4;
            for (int i = 0; i < LV; i++)
            begin
                head_reg[i] <= '0; tail_reg[i] <= '0; count_reg[i] <= '0;
            end
            cur_task_reg  <= '0;
            cur_idle_reg  <= 1'b1;
            cur_level_reg <= '0;
            qleft_reg     <= '0;
            ign_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mfqs_pkg::REG_Q0: quantum_reg[0] <= cfg_data;
                    mfqs_pkg::REG_Q1: quantum_reg[1] <= cfg_data;
                    mfqs_pkg::REG_Q2: quantum_reg[2] <= cfg_data;
                    mfqs_pkg::REG_Q3: quantum_reg[3] <= cfg_data;
                    mfqs_pkg::REG_LEVELS: levels_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end
            if (cmd.execute)
            begin
                ign_reg <= ign_c;
                if (tick_dec) qleft_reg <= qleft_reg - 1'b1;
                for (int i = 0; i < LV; i++)
                begin
                    logic pu, po;
                    pu = push_ok && push_lv == LV_W'(i);
                    po = do_select && sel_found && sel_lv == LV_W'(i);
                    if (pu) tail_reg[i] <= tail_reg[i] + 1'b1;
                    if (po) head_reg[i] <= head_reg[i] + 1'b1;
                    count_reg[i] <= count_reg[i] + CNT_W'(pu) - CNT_W'(po);
                end
                if (do_select)
                begin
                    cur_idle_reg  <= !sel_found;
                    cur_task_reg  <= sel_found ? (sel_from_push ? push_task : qs_rdata) : '0;
                    cur_level_reg <= sel_found ? sel_lv : '0;
                    qleft_reg     <= sel_found ? qload : '0;
                end
            end
        end
    end

    assign status.busy     = 1'b0;
    assign running_task    = cur_idle_reg ? '0 : cur_task_reg;
    assign running_is_idle = cur_idle_reg;
    assign event_ignored   = ign_reg;
endmodule

// File: rtl/mfqs_checker.sv
// Checker: port-level properties of the scheduler, bound to the top level.
module mfqs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [3:0] running_task,
    input logic running_is_idle
);
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && running_is_idle |-> running_task == 4'd0)
        else $error("idle result carries a task");
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request accepted while result stalled");
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##3 out_valid)
        else $error("result missing after request");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(running_task))
        else $error("stalled result changed");
endmodule

bind multilevel_feedback_queue_scheduler mfqs_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .running_task(out_ch.running_task), .running_is_idle(out_ch.running_is_idle));
